@@ hdl/ttw_pkg.sv @@
// Shared types and constants for the trend time-to-threshold warner.
// Used by ttw_regs, ttw_proj and the top level; no dependencies.
package ttw_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int NUM_W  = 16;
	localparam int DT_W   = 32;
	localparam int PROD_W = NUM_W + DT_W;
	localparam int DK_W   = 26;
	localparam int SEC_W  = 16;
	localparam int METRICS = 3;

	localparam logic [2:0] REG_OXY_LOW  = 3'd0;
	localparam logic [2:0] REG_PRS_LOW  = 3'd1;
	localparam logic [2:0] REG_PRS_HIGH = 3'd2;
	localparam logic [2:0] REG_THM_LOW  = 3'd3;
	localparam logic [2:0] REG_THM_HIGH = 3'd4;
	localparam logic [2:0] REG_HORIZON  = 3'd5;

	localparam logic [1:0] M_OXY = 2'd0;
	localparam logic [1:0] M_PRS = 2'd1;
	localparam logic [1:0] M_THM = 2'd2;

	typedef struct packed {
		logic        [13:0] oxy_low;
		logic        [14:0] prs_low;
		logic        [14:0] prs_high;
		logic signed [15:0] thm_low;
		logic signed [15:0] thm_high;
		logic        [15:0] horizon;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
	} proj_req_t;

	typedef struct packed {
		logic             done;
		logic             trend;
		logic [SEC_W-1:0] secs;
	} proj_rsp_t;

	typedef struct packed {
		logic        [31:0] time_ms;
		logic        [13:0] oxygen;
		logic        [14:0] pressure;
		logic signed [15:0] thermal;
	} hist_t;

endpackage

@@ hdl/ttw_regs.sv @@
// Configuration register file on an APB-style port.
// Depends on ttw_pkg for cfg_t and the register indexes.
module ttw_regs import ttw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.oxy_low  <= 14'd1900;
			cfg_q.prs_low  <= 15'd2900;
			cfg_q.prs_high <= 15'd10500;
			cfg_q.thm_low  <= 16'sd1000;
			cfg_q.thm_high <= 16'sd3500;
			cfg_q.horizon  <= 16'd120;
		end else if (wr) begin
			case (idx)
				REG_OXY_LOW:  cfg_q.oxy_low  <= pwdata[13:0];
				REG_PRS_LOW:  cfg_q.prs_low  <= pwdata[14:0];
				REG_PRS_HIGH: cfg_q.prs_high <= pwdata[14:0];
				REG_THM_LOW:  cfg_q.thm_low  <= pwdata[15:0];
				REG_THM_HIGH: cfg_q.thm_high <= pwdata[15:0];
				REG_HORIZON:  cfg_q.horizon  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OXY_LOW:  prdata = {18'b0, cfg_q.oxy_low};
			REG_PRS_LOW:  prdata = {17'b0, cfg_q.prs_low};
			REG_PRS_HIGH: prdata = {17'b0, cfg_q.prs_high};
			REG_THM_LOW:  prdata = {16'b0, cfg_q.thm_low};
			REG_THM_HIGH: prdata = {16'b0, cfg_q.thm_high};
			REG_HORIZON:  prdata = {16'b0, cfg_q.horizon};
			default:      prdata = '0;
		endcase
	end

endmodule

@@ hdl/ttw_proj.sv @@
// Shared projection unit: one multiply, then a restoring divide, one quotient bit a cycle.
// Decides num*dt <= horizon*den*1000 and gives the truncated seconds. Depends on ttw_pkg.
module ttw_proj import ttw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  proj_req_t        req,
	input  logic [DT_W-1:0]  dt,
	input  logic [SEC_W-1:0] horizon,
	output proj_rsp_t        rsp
);

	localparam int CNT_W = $clog2(SEC_W);

	typedef enum logic [4:0] {
		P_IDLE = 5'b00001,
		P_MUL  = 5'b00010,
		P_CHK  = 5'b00100,
		P_DIV  = 5'b01000,
		P_FIN  = 5'b10000
	} pstate_t;

	pstate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   num_q;
	logic [NUM_W-1:0]   den_q;
	logic [PROD_W-1:0]  prod_q;
	logic [DK_W-1:0]    dk_q;
	logic [DK_W-1:0]    rem_q;
	logic [SEC_W-1:0]   lo_q;
	logic               done_q;
	logic               trend_q;
	logic [SEC_W-1:0]   secs_q;
	logic [DK_W:0]      trial;
	logic               qbit;
	logic               ovf;

	assign trial = {rem_q, lo_q[SEC_W-1]};
	assign qbit  = (trial >= {1'b0, dk_q});
	assign ovf   = (prod_q[PROD_W-1:SEC_W] >= {6'b0, dk_q});
	assign rsp   = {done_q, trend_q, secs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ((state_q == P_CHK) && ovf) || (state_q == P_FIN);
			case (state_q)
				P_IDLE: if (req.start) state_q <= P_MUL;
				P_MUL:  state_q <= P_CHK;
				P_CHK: begin
					cnt_q   <= '0;
					state_q <= ovf ? P_IDLE : P_DIV;
				end
				P_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SEC_W - 1)) state_q <= P_FIN;
				end
				P_FIN:   state_q <= P_IDLE;
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			P_IDLE: begin
				num_q <= req.num;
				den_q <= req.den;
			end
			P_MUL: begin
				prod_q <= PROD_W'(num_q) * PROD_W'(dt);
				dk_q   <= {den_q, 10'b0} - DK_W'({den_q, 4'b0}) - DK_W'({den_q, 3'b0});
			end
			P_CHK: begin
				rem_q   <= prod_q[SEC_W+DK_W-1:SEC_W];
				lo_q    <= prod_q[SEC_W-1:0];
				trend_q <= 1'b0;
				secs_q  <= '0;
			end
			P_DIV: begin
				rem_q <= qbit ? DK_W'(trial - {1'b0, dk_q}) : trial[DK_W-1:0];
				lo_q  <= {lo_q[SEC_W-2:0], qbit};
			end
			P_FIN: begin
				trend_q <= (lo_q < horizon) || ((lo_q == horizon) && (rem_q == '0));
				secs_q  <= lo_q;
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/trend_time_to_threshold_warner_unit.sv @@
// Trend time-to-threshold warner top level: sequencer, unit history and result register.
// Sequence: read, then a select step for each metric in turn; a first sample or a zero time step
// goes from its first select straight to done, and a trending metric takes a pass on the shared
// multiply/divide unit (multiply, check, its 16-step divider, finish; no divide on a 16-bit overflow).
// Throughput: one sample at a time, taken only in idle; a waiting result stalls the next commit only.
// Reset: asynchronous, clears flags, control and registers to defaults. Uses ttw_pkg/regs/proj.
module trend_time_to_threshold_warner_unit import ttw_pkg::*; #(
	parameter int UNITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  logic [2:0]        unit_index,
	input  logic [31:0]       time_ms,
	input  logic [13:0]       oxygen_sample,
	input  logic [14:0]       pressure_sample,
	input  logic signed [15:0] thermal_sample,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [2:0]        unit_echo,
	output logic              oxygen_warn,
	output logic [15:0]       oxygen_seconds,
	output logic              pressure_warn,
	output logic [15:0]       pressure_seconds,
	output logic              thermal_warn,
	output logic [15:0]       thermal_seconds
);

	localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_SEL  = 5'b00100,
		S_WAIT = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	cfg_t       cfg;
	proj_req_t  req;
	proj_rsp_t  rsp;

	state_t              state_q;
	logic                req_start_q;
	logic [NUM_W-1:0]    req_num_q;
	logic [NUM_W-1:0]    req_den_q;
	logic [1:0]          m_q;
	logic [UW-1:0]       idx_q;
	logic                inr_q;
	logic [2:0]          unit_q;
	hist_t               cur_q;
	hist_t               rd_q;
	hist_t               mem [UNITS];
	logic [UNITS-1:0]    seen_q;
	logic [2:0]          warned_q [UNITS];
	logic [2:0]          trend_q;
	logic [SEC_W-1:0]    secs_q [METRICS];

	logic [DT_W-1:0]     dt;
	logic                active;
	logic                commit;
	logic signed [16:0]  prev, cur, lim_lo, lim_hi;
	logic                has_hi, fall, rise;
	logic signed [16:0]  num_d, den_d;
	logic [2:0]          fire;

	ttw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ttw_proj u_proj (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.dt      (dt),
		.horizon (cfg.horizon),
		.rsp     (rsp)
	);

	assign req          = {req_start_q, req_num_q, req_den_q};
	assign sample_ready = (state_q == S_IDLE);
	assign dt           = cur_q.time_ms - rd_q.time_ms;
	assign active       = inr_q && seen_q[idx_q] && (dt != '0);
	assign commit       = (state_q == S_DONE) && (!result_valid || result_ready);
	assign fire         = trend_q & ~warned_q[idx_q];

	always_comb begin
		has_hi = 1'b1;
		case (m_q)
			M_OXY: begin
				prev   = {3'b0, rd_q.oxygen};
				cur    = {3'b0, cur_q.oxygen};
				lim_lo = {3'b0, cfg.oxy_low};
				lim_hi = '0;
				has_hi = 1'b0;
			end
			M_PRS: begin
				prev   = {2'b0, rd_q.pressure};
				cur    = {2'b0, cur_q.pressure};
				lim_lo = {2'b0, cfg.prs_low};
				lim_hi = {2'b0, cfg.prs_high};
			end
			M_THM: begin
				prev   = {rd_q.thermal[15], rd_q.thermal};
				cur    = {cur_q.thermal[15], cur_q.thermal};
				lim_lo = {cfg.thm_low[15], cfg.thm_low};
				lim_hi = {cfg.thm_high[15], cfg.thm_high};
			end
			default: begin
				prev   = '0;
				cur    = '0;
				lim_lo = '0;
				lim_hi = '0;
				has_hi = 1'b0;
			end
		endcase
		fall  = (cur < prev) && (cur > lim_lo);
		rise  = has_hi && (cur > prev) && (cur < lim_hi);
		num_d = fall ? (cur - lim_lo) : (lim_hi - cur);
		den_d = fall ? (prev - cur) : (cur - prev);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			m_q          <= M_OXY;
			req_start_q  <= 1'b0;
			result_valid <= 1'b0;
			seen_q       <= '0;
			for (int i = 0; i < UNITS; i++) warned_q[i] <= '0;
		end else begin
			req_start_q  <= (state_q == S_SEL) && active && (fall || rise);
			result_valid <= commit || (result_valid && !result_ready);
			case (state_q)
				S_IDLE: if (sample_valid) state_q <= S_READ;
				S_READ: begin
					m_q     <= M_OXY;
					state_q <= S_SEL;
				end
				S_SEL: begin
					if (!active) begin
						state_q <= S_DONE;
					end else if (fall || rise) begin
						state_q <= S_WAIT;
					end else if (m_q == M_THM) begin
						state_q <= S_DONE;
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
				S_WAIT: if (rsp.done) begin
					if (m_q == M_THM) begin
						state_q <= S_DONE;
					end else begin
						m_q     <= m_q + 1'b1;
						state_q <= S_SEL;
					end
				end
				S_DONE: if (commit) begin
					state_q <= S_IDLE;
					if (inr_q) seen_q[idx_q] <= 1'b1;
					if (active) warned_q[idx_q] <= trend_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q];
		if (commit && inr_q) mem[idx_q] <= cur_q;
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			idx_q            <= UW'(unit_index);
			inr_q            <= (32'(unit_index) < 32'(UNITS));
			unit_q           <= unit_index;
			cur_q.time_ms    <= time_ms;
			cur_q.oxygen     <= oxygen_sample;
			cur_q.pressure   <= pressure_sample;
			cur_q.thermal    <= thermal_sample;
			trend_q          <= '0;
		end
		req_num_q <= num_d[NUM_W-1:0];
		req_den_q <= den_d[NUM_W-1:0];
		if (state_q == S_SEL && active && !(fall || rise)) trend_q[m_q] <= 1'b0;
		if (state_q == S_WAIT && rsp.done) begin
			trend_q[m_q] <= rsp.trend;
			secs_q[m_q]  <= rsp.secs;
		end
		if (commit) begin
			unit_echo        <= unit_q;
			oxygen_warn      <= active & fire[0];
			oxygen_seconds   <= (active & fire[0]) ? secs_q[0] : '0;
			pressure_warn    <= active & fire[1];
			pressure_seconds <= (active & fire[1]) ? secs_q[1] : '0;
			thermal_warn     <= active & fire[2];
			thermal_seconds  <= (active & fire[2]) ? secs_q[2] : '0;
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for trend_time_to_threshold_warner_unit: directed and random
// sample beats are checked against a per-unit trend predictor over several register settings.
// Depends on ttw_pkg and the RTL of the warner.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ttw_pkg::*;

	localparam int UNITS       = 8;
	localparam int NUM_REGS    = 6;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 50;
	localparam logic [2:0] REG_SPARE = 3'd6;

	typedef struct packed {
		logic [2:0]  unit_no;
		logic        ox_warn;
		logic [15:0] ox_secs;
		logic        pr_warn;
		logic [15:0] pr_secs;
		logic        th_warn;
		logic [15:0] th_secs;
	} verdict_t;

	class warn_scoreboard;
		longint          oxy_low, prs_low, prs_high, thm_low, thm_high;
		longint unsigned horizon;
		bit              seen [UNITS];
		logic [31:0]     last_time [UNITS];
		longint          last_level [UNITS][METRICS];
		bit [2:0]        warned [UNITS];
		verdict_t        pending_verdicts [$];
		int              mismatches, samples, verdicts;
		int              fired [METRICS];

		function new();
			oxy_low = 1900;
			prs_low = 2900;
			prs_high = 10500;
			thm_low = 1000;
			thm_high = 3500;
			horizon = 120;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_OXY_LOW:  oxy_low = v[13:0];
				REG_PRS_LOW:  prs_low = v[14:0];
				REG_PRS_HIGH: prs_high = v[14:0];
				REG_THM_LOW:  thm_low = $signed(v[15:0]);
				REG_THM_HIGH: thm_high = $signed(v[15:0]);
				REG_HORIZON:  horizon = v[15:0];
				default: ;
			endcase
		endfunction

		function bit reaches_limit(longint prev, longint cur, bit has_high, longint low,
				longint high, longint unsigned dt, output longint unsigned secs);
			longint unsigned num, den;
			secs = 0;
			if (cur < prev && cur > low) begin
				num = cur - low;
				den = prev - cur;
			end else if (has_high && cur > prev && cur < high) begin
				num = high - cur;
				den = cur - prev;
			end else begin
				return 1'b0;
			end
			den = den * 1000;
			if (num * dt > horizon * den)
				return 1'b0;
			secs = num * dt / den;
			return 1'b1;
		endfunction

		function logic [15:0] clip_secs(bit fire, longint unsigned secs);
			if (!fire)
				return 16'd0;
			return (secs > 64'hFFFF) ? 16'hFFFF : secs[15:0];
		endfunction

		function void note_sample(logic [2:0] u, logic [31:0] now, logic [13:0] ox,
				logic [14:0] pr, logic signed [15:0] th);
			verdict_t        v;
			longint          cur [METRICS];
			longint unsigned secs [METRICS];
			bit              trend [METRICS];
			bit              fire [METRICS];
			logic [31:0]     step_ms;
			longint unsigned dt;
			int              k;
			v = '0;
			v.unit_no = u;
			for (k = 0; k < METRICS; k++) begin
				secs[k] = 0;
				fire[k] = 1'b0;
				trend[k] = 1'b0;
			end
			cur[M_OXY] = ox;
			cur[M_PRS] = pr;
			cur[M_THM] = th;
			samples++;
			if (!seen[u]) begin
				seen[u] = 1'b1;
			end else begin
				step_ms = now - last_time[u];
				dt = step_ms;
				if (dt != 0) begin
					trend[M_OXY] = reaches_limit(last_level[u][M_OXY], cur[M_OXY], 1'b0,
						oxy_low, 0, dt, secs[M_OXY]);
					trend[M_PRS] = reaches_limit(last_level[u][M_PRS], cur[M_PRS], 1'b1,
						prs_low, prs_high, dt, secs[M_PRS]);
					trend[M_THM] = reaches_limit(last_level[u][M_THM], cur[M_THM], 1'b1,
						thm_low, thm_high, dt, secs[M_THM]);
					for (k = 0; k < METRICS; k++) begin
						if (!trend[k]) begin
							warned[u][k] = 1'b0;
						end else if (!warned[u][k]) begin
							warned[u][k] = 1'b1;
							fire[k] = 1'b1;
							fired[k]++;
						end
					end
				end
			end
			last_time[u] = now;
			for (k = 0; k < METRICS; k++)
				last_level[u][k] = cur[k];
			v.ox_warn = fire[M_OXY];
			v.ox_secs = clip_secs(fire[M_OXY], secs[M_OXY]);
			v.pr_warn = fire[M_PRS];
			v.pr_secs = clip_secs(fire[M_PRS], secs[M_PRS]);
			v.th_warn = fire[M_THM];
			v.th_secs = clip_secs(fire[M_THM], secs[M_THM]);
			pending_verdicts.push_back(v);
		endfunction

		function string describe(verdict_t v);
			return $sformatf("unit %0d ox %b/%0d pr %b/%0d th %b/%0d", v.unit_no,
				v.ox_warn, v.ox_secs, v.pr_warn, v.pr_secs, v.th_warn, v.th_secs);
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ns: %s", $time, msg);
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			string    bad;
			verdicts++;
			if (pending_verdicts.size() == 0) begin
				note_mismatch({"result with no sample pending: ", describe(got)});
				return;
			end
			want = pending_verdicts.pop_front();
			bad = "";
			if (got.unit_no !== want.unit_no) bad = {bad, " unit_echo"};
			if (got.ox_warn !== want.ox_warn) bad = {bad, " oxygen_warn"};
			if (got.ox_secs !== want.ox_secs) bad = {bad, " oxygen_seconds"};
			if (got.pr_warn !== want.pr_warn) bad = {bad, " pressure_warn"};
			if (got.pr_secs !== want.pr_secs) bad = {bad, " pressure_seconds"};
			if (got.th_warn !== want.th_warn) bad = {bad, " thermal_warn"};
			if (got.th_secs !== want.th_secs) bad = {bad, " thermal_seconds"};
			if (bad != "")
				note_mismatch({"mismatch in", bad, ": expected ", describe(want),
					", got ", describe(got)});
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              sample_valid = 1'b0;
	logic              sample_ready;
	logic [2:0]        unit_index = '0;
	logic [31:0]       time_ms = '0;
	logic [13:0]       oxygen_sample = '0;
	logic [14:0]       pressure_sample = '0;
	logic signed [15:0] thermal_sample = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic [2:0]        unit_echo;
	logic              oxygen_warn;
	logic [15:0]       oxygen_seconds;
	logic              pressure_warn;
	logic [15:0]       pressure_seconds;
	logic              thermal_warn;
	logic [15:0]       thermal_seconds;

	warn_scoreboard predictor = new();
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             quiet_cycles = 0;
	int             settings_applied = 0;
	int             setting_order [PHASES] = '{1, 3, 2, 4, 0, 5, 3, 1};
	bit [31:0]      gen_time [UNITS];
	int             gen_ox [UNITS];
	int             gen_pr [UNITS];
	int             gen_th [UNITS];

	trend_time_to_threshold_warner_unit #(.UNITS(UNITS)) u_top (.*);

	always #5 clk = ~clk;

	always @(negedge clk)
		result_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				predictor.write_reg(paddr[4:2], pwdata);
			if (result_valid && result_ready)
				predictor.check_verdict(verdict_t'{unit_echo, oxygen_warn, oxygen_seconds,
					pressure_warn, pressure_seconds, thermal_warn, thermal_seconds});
			if (sample_valid && sample_ready)
				predictor.note_sample(unit_index, time_ms, oxygen_sample, pressure_sample,
					thermal_sample);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
					quiet_cycles, predictor.pending_verdicts.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic write_apb(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	task automatic apply_setting(input int kind);
		logic [31:0] vals [NUM_REGS];
		int          i;
		repeat (4) @(negedge clk);
		case (kind)
			0: vals = '{1900, 2900, 10500, 1000, 3500, 120};
			1: vals = '{0, 0, 32767, 32'hFFFF_8000, 32767, 65535};
			2: vals = '{16383, 32767, 0, 32767, 32'h0000_8000, 0};
			default: begin
				for (i = 0; i < NUM_REGS; i++)
					vals[i] = $urandom;
				vals[REG_OXY_LOW][13:0] = 14'($urandom_range(0, 10000));
				vals[REG_PRS_LOW][14:0] = 15'($urandom_range(500, 12000));
				vals[REG_PRS_HIGH][14:0] = 15'($urandom_range(12000, 32767));
				vals[REG_THM_LOW][15:0] = 16'(-int'($urandom_range(0, 4000)));
				vals[REG_THM_HIGH][15:0] = 16'($urandom_range(500, 8000));
				vals[REG_HORIZON][15:0] = 16'($urandom_range(1, 3000));
			end
		endcase
		for (i = 0; i < NUM_REGS; i++)
			write_apb(ADDR_W'(4 * i), vals[i]);
		write_apb(ADDR_W'(4 * REG_SPARE), $urandom);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_applied++;
	endtask

	// entered and left at a falling edge; valid is left high after the beat
	task automatic send_sample(input bit [2:0] u, input bit [31:0] t, input bit [13:0] ox,
			input bit [14:0] pr, input bit [15:0] th);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_valid <= 1'b1;
		unit_index <= u;
		time_ms <= t;
		oxygen_sample <= ox;
		pressure_sample <= pr;
		thermal_sample <= th;
		gen_time[u] = t;
		gen_ox[u] = ox;
		gen_pr[u] = pr;
		gen_th[u] = int'($signed(th));
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		sample_valid <= 1'b0;
		do @(negedge clk); while (predictor.pending_verdicts.size() != 0);
	endtask

	// walks a metric mostly towards its limits so that projections can land inside the horizon
	function automatic int next_level(int prev, int low, int high, bit has_high,
			int lo_b, int hi_b);
		int mode, cur;
		mode = $urandom_range(9);
		if (!has_high && mode >= 6 && mode <= 8)
			mode = 2;
		case (mode)
			0: cur = prev;
			1: cur = lo_b + int'($urandom_range(hi_b - lo_b));
			2, 3, 4, 5: begin
				cur = prev - int'($urandom_range(1, 300));
				if (cur <= low)
					cur = low + int'($urandom_range(1, 1500));
			end
			6, 7, 8: begin
				cur = prev + int'($urandom_range(1, 300));
				if (cur >= high)
					cur = high - int'($urandom_range(1, 1500));
			end
			default: cur = (has_high && $urandom_range(1)) ? high : low;
		endcase
		if (cur < lo_b)
			cur = lo_b;
		if (cur > hi_b)
			cur = hi_b;
		return cur;
	endfunction

	task automatic send_random();
		bit [2:0]  u;
		bit [31:0] dt;
		int        r;
		u = 3'($urandom_range(UNITS - 1));
		r = $urandom_range(99);
		if (r < 10) begin
			send_sample(u, $urandom, 14'($urandom), 15'($urandom), 16'($urandom));
		end else begin
			if (r < 18)
				dt = 0;
			else if (r < 24)
				dt = $urandom;
			else
				dt = $urandom_range(1, 4000);
			send_sample(u, gen_time[u] + dt,
				14'(next_level(gen_ox[u], int'(predictor.oxy_low), 0, 1'b0, 0, 16383)),
				15'(next_level(gen_pr[u], int'(predictor.prs_low), int'(predictor.prs_high),
					1'b1, 0, 32767)),
				16'(next_level(gen_th[u], int'(predictor.thm_low), int'(predictor.thm_high),
					1'b1, -32768, 32767)));
		end
	endtask

	initial begin
		int phase, n;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limits: oxygen 1900, pressure 2900..10500, thermal 1000..3500, horizon 120
		send_sample(0, 32'd0, 14'd0, 15'd0, 16'h8000);
		send_sample(7, 32'hFFFF_FFFF, 14'h3FFF, 15'h7FFF, 16'h7FFF);
		send_sample(0, 32'd0, 2500, 5000, 2000);
		send_sample(0, 32'd1000, 2400, 5000, 2000);
		send_sample(0, 32'd2000, 2300, 5000, 2000);
		send_sample(0, 32'd2000, 2200, 5000, 2000);
		send_sample(0, 32'd3000, 2350, 5000, 2000);
		send_sample(0, 32'd4000, 2250, 5000, 2000);
		send_sample(0, 32'd5000, 1900, 5000, 2000);
		send_sample(0, 32'd6000, 1900, 10000, 2000);
		send_sample(0, 32'd7000, 1900, 9000, 2000);
		send_sample(0, 32'd8000, 1900, 9000, 1500);
		send_sample(0, 32'd9000, 1900, 9000, 3000);
		send_sample(7, 32'd999, 16000, 32000, 32000);
		send_sample(1, 32'd100, 5000, 5000, 0);
		send_sample(1, 32'd60100, 4999, 5001, 1);
		send_sample(2, 32'd0, 2021, 5000, 2000);
		send_sample(2, 32'd1000, 2020, 5000, 2000);
		send_sample(3, 32'd0, 2022, 5000, 2000);
		send_sample(3, 32'd1000, 2021, 5000, 2000);
		wait_results_drained();

		for (phase = 0; phase < PHASES; phase++) begin
			apply_setting(setting_order[phase]);
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 2 && n == PHASE_ITEMS / 2)
					wait_results_drained();
				send_random();
			end
			wait_results_drained();
		end

		repeat (80) @(posedge clk);
		$display("Covered %0d sample beats and %0d result beats over %0d register settings.",
			predictor.samples, predictor.verdicts, settings_applied);
		$display("New warnings: oxygen %0d, pressure %0d, temperature %0d; mismatches %0d.",
			predictor.fired[M_OXY], predictor.fired[M_PRS], predictor.fired[M_THM],
			predictor.mismatches);
		if (predictor.mismatches == 0 && predictor.pending_verdicts.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
